// ===== sv/aclk_pkg.sv =====
// ----------------------------------------------------------------------------
// aclk_pkg - shared types and helpers for the alarm clock time keeper
// Holds command and alarm mode codes, register indexes, the configuration
// bundle and the small normalizing functions for set and load commands.
// ----------------------------------------------------------------------------
package aclk_pkg;

	localparam int unsigned HourW   = 5;
	localparam int unsigned MinW    = 6;
	localparam int unsigned SecW    = 6;
	localparam int unsigned SnoozeW = 5;
	localparam int unsigned PaddrW  = 4;
	localparam int unsigned PdataW  = 32;
	localparam int unsigned DayMinW = 11;

	localparam logic [HourW-1:0]   HourMax     = 5'd23;
	localparam logic [MinW-1:0]    MinLimit    = 6'd60;
	localparam logic [SecW-1:0]    SecLimit    = 6'd60;
	localparam logic [HourW-1:0]   HourLimit   = 5'd24;
	localparam logic [DayMinW-1:0] MinPerDay   = 11'd1440;
	localparam logic [DayMinW-1:0] MinPerHour  = 11'd60;

	localparam logic               RstAlarmEnable  = 1'b1;
	localparam logic [HourW-1:0]   RstAlarmHour    = 5'd8;
	localparam logic [MinW-1:0]    RstAlarmMinute  = 6'd0;
	localparam logic [SnoozeW-1:0] RstSnoozeLength = 5'd5;

	typedef enum logic [2:0] {
		FUNC_TICK   = 3'd0,
		FUNC_SET    = 3'd1,
		FUNC_LOAD   = 3'd2,
		FUNC_SNOOZE = 3'd3,
		FUNC_STOP   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		MODE_WAITING = 2'd0,
		MODE_RINGING = 2'd1,
		MODE_SNOOZED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_ALARM_ENABLE  = 2'd0,
		REG_ALARM_HOUR    = 2'd1,
		REG_ALARM_MINUTE  = 2'd2,
		REG_SNOOZE_LENGTH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               alarm_enable;
		logic [HourW-1:0]   alarm_hour;
		logic [MinW-1:0]    alarm_minute;
		logic [SnoozeW-1:0] snooze_length;
	} cfg_t;

	// Below zero wraps to 23, above 23 wraps to 0.
	function automatic logic [HourW-1:0] norm_hours(input logic signed [5:0] nh);
		logic [HourW-1:0] r;
		begin
			if (nh[5]) begin
				r = HourMax;
			end else if (nh[4:0] > HourMax) begin
				r = '0;
			end else begin
				r = nh[4:0];
			end
			return r;
		end
	endfunction

	// Offset by 180 (a multiple of 60) to make the value positive, then
	// strip 240, 120 and 60 in turn.
	function automatic logic [MinW-1:0] norm_minutes(input logic signed [7:0] nm);
		logic [8:0] m;
		begin
			m = {nm[7], nm} + 9'd180;
			if (m >= 9'd240) m = m - 9'd240;
			if (m >= 9'd120) m = m - 9'd120;
			if (m >= 9'd60)  m = m - 9'd60;
			return m[MinW-1:0];
		end
	endfunction

endpackage

// ===== sv/aclk_cfg.sv =====
// ----------------------------------------------------------------------------
// aclk_cfg - configuration register file
// APB-style slave holding alarm enable, alarm hour, alarm minute and snooze
// length; zero wait states.
// ----------------------------------------------------------------------------
module aclk_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aclk_pkg::PaddrW-1:0] paddr,
	input  logic [aclk_pkg::PdataW-1:0] pwdata,
	output logic [aclk_pkg::PdataW-1:0] prdata,
	output logic                        pready,
	output aclk_pkg::cfg_t              cfg
);
	import aclk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_enable  <= RstAlarmEnable;
			cfg_q.alarm_hour    <= RstAlarmHour;
			cfg_q.alarm_minute  <= RstAlarmMinute;
			cfg_q.snooze_length <= RstSnoozeLength;
		end else if (wr_en) begin
			unique case (idx)
				REG_ALARM_ENABLE:  cfg_q.alarm_enable  <= pwdata[0];
				REG_ALARM_HOUR:    cfg_q.alarm_hour    <= pwdata[HourW-1:0];
				REG_ALARM_MINUTE:  cfg_q.alarm_minute  <= pwdata[MinW-1:0];
				REG_SNOOZE_LENGTH: cfg_q.snooze_length <= pwdata[SnoozeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_ALARM_ENABLE:  prdata[0]           = cfg_q.alarm_enable;
			REG_ALARM_HOUR:    prdata[HourW-1:0]   = cfg_q.alarm_hour;
			REG_ALARM_MINUTE:  prdata[MinW-1:0]    = cfg_q.alarm_minute;
			REG_SNOOZE_LENGTH: prdata[SnoozeW-1:0] = cfg_q.snooze_length;
			default: ;
		endcase
	end

endmodule

// ===== sv/aclk_core.sv =====
// ----------------------------------------------------------------------------
// aclk_core - time keeping and alarm datapath
// Input register, one pass of update logic, and the time/alarm state that
// doubles as the result register.
// ----------------------------------------------------------------------------
module aclk_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  aclk_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   func,
	input  logic                         square_wave_level,
	input  logic signed [5:0]            set_hours,
	input  logic signed [7:0]            set_minutes,
	input  logic [5:0]                   new_seconds,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [aclk_pkg::HourW-1:0]   hours,
	output logic [aclk_pkg::MinW-1:0]    minutes,
	output logic [aclk_pkg::SecW-1:0]    seconds,
	output logic [1:0]                   alarm_status,
	output logic                         minute_changed
);
	import aclk_pkg::*;

	// request held in the input register
	logic              valid_s1;
	logic [2:0]        func_s1;
	logic              level_s1;
	logic signed [5:0] nh_s1;
	logic signed [7:0] nm_s1;
	logic [5:0]        ns_s1;

	// state, shown directly on the result ports
	logic [HourW-1:0] hour_q;
	logic [MinW-1:0]  min_q;
	logic [SecW-1:0]  sec_q;
	mode_t            mode_q;
	logic [HourW-1:0] snz_hour_q;
	logic [MinW-1:0]  snz_min_q;
	logic             changed_q;
	logic             out_valid_q;

	logic             advance;
	logic             in_take;

	logic [HourW-1:0] hour_d;
	logic [MinW-1:0]  min_d;
	logic [SecW-1:0]  sec_d;
	mode_t            mode_d;
	logic [HourW-1:0] snz_hour_d;
	logic [MinW-1:0]  snz_min_d;
	logic             changed_d;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1  <= func;
			level_s1 <= square_wave_level;
			nh_s1    <= set_hours;
			nm_s1    <= set_minutes;
			ns_s1    <= new_seconds;
		end
	end

	// time and plain command updates
	always_comb begin
		logic [SecW-1:0]    sec_inc;
		logic [MinW-1:0]    min_inc;
		logic [HourW-1:0]   hour_inc;
		logic [DayMinW-1:0] now_m;
		logic [DayMinW-1:0] then_m;
		logic [DayMinW-1:0] elapsed;

		hour_d     = hour_q;
		min_d      = min_q;
		sec_d      = sec_q;
		snz_hour_d = snz_hour_q;
		snz_min_d  = snz_min_q;
		changed_d  = 1'b0;
		sec_inc    = sec_q + 1'b1;
		min_inc    = min_q + 1'b1;
		hour_inc   = hour_q + 1'b1;

		unique case (func_s1)
			FUNC_TICK: begin
				if (level_s1) begin
					if (sec_inc >= SecLimit) begin
						sec_d     = '0;
						changed_d = 1'b1;
						if (min_inc >= MinLimit) begin
							min_d  = '0;
							hour_d = (hour_inc >= HourLimit) ? '0 : hour_inc;
						end else begin
							min_d = min_inc;
						end
					end else begin
						sec_d = sec_inc;
					end
				end
			end
			FUNC_SET: begin
				hour_d = norm_hours(nh_s1);
				min_d  = norm_minutes(nm_s1);
			end
			FUNC_LOAD: begin
				hour_d = norm_hours(nh_s1);
				min_d  = norm_minutes(nm_s1);
				sec_d  = (ns_s1 >= SecLimit) ? ns_s1 - SecLimit : ns_s1;
			end
			FUNC_SNOOZE: begin
				snz_hour_d = hour_q;
				snz_min_d  = min_q;
			end
			default: ;
		endcase

		now_m   = DayMinW'(hour_d) * MinPerHour + DayMinW'(min_d);
		then_m  = DayMinW'(snz_hour_q) * MinPerHour + DayMinW'(snz_min_q);
		elapsed = (now_m >= then_m) ? now_m - then_m : now_m + MinPerDay - then_m;

		// alarm mode next state
		mode_d = mode_q;
		unique case (func_s1)
			FUNC_TICK: begin
				if (level_s1) begin
					if (cfg.alarm_enable && cfg.alarm_hour == hour_d &&
					    cfg.alarm_minute == min_d && sec_d == '0 &&
					    mode_q == MODE_WAITING) begin
						mode_d = MODE_RINGING;
					end else if (mode_q == MODE_SNOOZED &&
					             elapsed > DayMinW'(cfg.snooze_length)) begin
						mode_d = MODE_RINGING;
					end
				end
			end
			FUNC_SNOOZE: begin
				if (mode_q == MODE_RINGING) mode_d = MODE_SNOOZED;
			end
			FUNC_STOP: mode_d = MODE_WAITING;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q      <= '0;
			min_q       <= '0;
			sec_q       <= '0;
			mode_q      <= MODE_WAITING;
			snz_hour_q  <= '0;
			snz_min_q   <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				hour_q     <= hour_d;
				min_q      <= min_d;
				sec_q      <= sec_d;
				mode_q     <= mode_d;
				snz_hour_q <= snz_hour_d;
				snz_min_q  <= snz_min_d;
				changed_q  <= changed_d;
			end
		end
	end

	// result ports
	always_comb begin
		out_valid      = out_valid_q;
		hours          = hour_q;
		minutes        = min_q;
		seconds        = sec_q;
		alarm_status   = mode_q;
		minute_changed = changed_q;
	end

endmodule

// ===== sv/alarm_clock_time_keeper.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_time_keeper - 24-hour time of day with alarm and snooze
// Ticks, set/load, snooze and stop requests update the time and the alarm
// mode; every request returns the time and mode after it.
// ----------------------------------------------------------------------------
//
//  channel | handshake                         | payload
//  --------+-----------------------------------+---------------------------------
//  in      | in_valid / in_stall               | func, square_wave_level,
//          |                                   | set_hours, set_minutes, new_seconds
//  out     | out_valid / out_stall             | hours, minutes, seconds,
//          |                                   | alarm_status, minute_changed
//  cfg     | psel/penable/pwrite, pready = 1   | paddr, pwdata, prdata
//
//  One request per cycle sustained while out_stall is low; a taken request
//  passes through the input register, then the time/alarm state register,
//  whose outputs are the result ports.
//  The state registers are the result register, so a stalled result holds
//  while the next request waits in the input register.
//  in_stall rises only when both the input register and the result are held.
//  arst_n clears the time to 00:00:00, the alarm to waiting, and loads the
//  register reset values; no clearing pass is needed.
//
module alarm_clock_time_keeper (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aclk_pkg::PaddrW-1:0]  paddr,
	input  logic [aclk_pkg::PdataW-1:0]  pwdata,
	output logic [aclk_pkg::PdataW-1:0]  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   func,
	input  logic                         square_wave_level,
	input  logic signed [5:0]            set_hours,
	input  logic signed [7:0]            set_minutes,
	input  logic [5:0]                   new_seconds,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [aclk_pkg::HourW-1:0]   hours,
	output logic [aclk_pkg::MinW-1:0]    minutes,
	output logic [aclk_pkg::SecW-1:0]    seconds,
	output logic [1:0]                   alarm_status,
	output logic                         minute_changed
);
	import aclk_pkg::*;

	// alarm settings; write them only while no request is in flight (not enforced here)
	cfg_t cfg;

	aclk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// time keeping and alarm state; hold results while out_stall is high
	aclk_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.func              (func),
		.square_wave_level (square_wave_level),
		.set_hours         (set_hours),
		.set_minutes       (set_minutes),
		.new_seconds       (new_seconds),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.hours             (hours),
		.minutes           (minutes),
		.seconds           (seconds),
		.alarm_status      (alarm_status),
		.minute_changed    (minute_changed)
	);

endmodule

// ===== sv/aclk_checker.sv =====
// ----------------------------------------------------------------------------
// aclk_checker - port-level checks for the alarm clock time keeper
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module aclk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [aclk_pkg::HourW-1:0] hours,
	input logic [aclk_pkg::MinW-1:0]  minutes,
	input logic [aclk_pkg::SecW-1:0]  seconds,
	input logic [1:0]                 alarm_status,
	input logic                       minute_changed
);
	import aclk_pkg::*;

	// a held result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hours) && $stable(minutes) &&
		$stable(seconds) && $stable(alarm_status) && $stable(minute_changed))
		else $error("result payload changed while stalled");

	// requests back up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a held result");

	// a fresh result follows a taken request through the input and state registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching request");

endmodule

bind alarm_clock_time_keeper aclk_checker u_aclk_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.hours          (hours),
	.minutes        (minutes),
	.seconds        (seconds),
	.alarm_status   (alarm_status),
	.minute_changed (minute_changed)
);
